// File: hdl/texel_store_format_convert_defines.svh
// assertion helpers shared by the texel store rtl
`ifndef TEXEL_STORE_FORMAT_CONVERT_DEFINES_SVH
`define TEXEL_STORE_FORMAT_CONVERT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TSFC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TSFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tsfc_pkg.sv
`timescale 1ns / 1ps

package tsfc_pkg;

    // default size of the byte store
    localparam int MEM_BYTES_DEF = 65536;

    // configuration port
    localparam int PADDR_W = 5;
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_GRID_WIDTH    = 3'd0;
    localparam reg_idx_t REG_GRID_HEIGHT   = 3'd1;
    localparam reg_idx_t REG_GRID_DEPTH    = 3'd2;
    localparam reg_idx_t REG_CHANNEL_COUNT = 3'd3;
    localparam reg_idx_t REG_CHANNEL_BYTES = 3'd4;

    // channel format codes
    typedef logic [1:0] fmt_t;
    localparam fmt_t FMT_8   = 2'd0;
    localparam fmt_t FMT_16  = 2'd1;
    localparam fmt_t FMT_32  = 2'd2;
    localparam fmt_t FMT_32X = 2'd3;

    // address arithmetic widths
    localparam int ZH_W  = 26;
    localparam int LIN_W = 40;
    localparam int OFF_W = 45;
    typedef logic [ZH_W-1:0]  zh_t;
    typedef logic [LIN_W-1:0] lin_t;
    typedef logic [OFF_W-1:0] off_t;
    typedef logic [OFF_W:0]   off_sum_t;

    // controller states
    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_ROW   = 8'b0000_0100,
        ST_LIN   = 8'b0000_1000,
        ST_OFF   = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_XFER  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // unused format code behaves as 32-bit
    function automatic fmt_t fmt_norm(input fmt_t code);
        fmt_t r;
        r = (code == FMT_32X) ? FMT_32 : code;
        return r;
    endfunction

    // stored bytes per channel (1, 2 or 4) to format code
    function automatic fmt_t bytes_fmt(input logic [2:0] nbytes);
        fmt_t r;
        unique case (nbytes)
            3'd1:    r = FMT_8;
            3'd2:    r = FMT_16;
            default: r = FMT_32;
        endcase
        return r;
    endfunction

    // all ones in the format width
    function automatic logic [31:0] fmt_mask(input fmt_t code);
        logic [31:0] r;
        unique case (code)
            FMT_8:   r = 32'h0000_00FF;
            FMT_16:  r = 32'h0000_FFFF;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

    // widen by bit replication, narrow by keeping the top bits
    function automatic logic [31:0] fmt_convert(input logic [31:0] v, input fmt_t from,
                                                input fmt_t to);
        logic [31:0] r;
        unique case ({from, to})
            {FMT_8, FMT_8}:   r = {24'd0, v[7:0]};
            {FMT_8, FMT_16}:  r = {16'd0, v[7:0], v[7:0]};
            {FMT_8, FMT_32}:  r = {4{v[7:0]}};
            {FMT_16, FMT_8}:  r = {24'd0, v[15:8]};
            {FMT_16, FMT_16}: r = {16'd0, v[15:0]};
            {FMT_16, FMT_32}: r = {2{v[15:0]}};
            {FMT_32, FMT_8}:  r = {24'd0, v[31:24]};
            {FMT_32, FMT_16}: r = {16'd0, v[31:16]};
            {FMT_32, FMT_32}: r = v;
            default:          r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/texel_store_format_convert.sv
// channel  | dir | ports            | carries
// ---------+-----+------------------+-------------------------------------------
// s_       | in  | tvalid/tready    | one texel read or write per transaction
// m_       | out | tvalid/tready    | one result per input transaction
// apb      | in  | psel..pready     | grid size and texel layout registers
//
// An access that faults or whose texel has no bytes skips the byte transfer; a
// texel holds n = channel_count * channel_bytes bytes (0..16). The single byte
// port of the texel store moves one byte per cycle and the offset takes three
// multiply stages.
// After reset a clearing pass writes zero to all MEM_BYTES bytes, one per cycle,
// with s_tready low; register writes are taken throughout.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and only stalls at its end if that result is still not taken.
`timescale 1ns / 1ps
`include "texel_store_format_convert_defines.svh"

module texel_store_format_convert import tsfc_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // apb register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // coord_x, coord_y, coord_z, red, green, blue, alpha, 4 bits zero pad
    input  logic [167:0]       s_tdata,
    // action, access_format
    input  logic [2:0]         s_tuser,
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [127:0]       m_tdata,
    // fault
    output logic [0:0]         m_tuser
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    localparam off_sum_t MEM_LIM = off_sum_t'(MEM_BYTES);

    // control registers
    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [4:0]     k_reg, k_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [12:0]    cfg_width_reg, cfg_width_next;
    logic [12:0]    cfg_height_reg, cfg_height_next;
    logic [12:0]    cfg_depth_reg, cfg_depth_next;
    logic [2:0]     cfg_count_reg, cfg_count_next;
    logic [2:0]     cfg_bytes_reg, cfg_bytes_next;

    // payload registers
    logic           action_reg, action_next;
    fmt_t           fmt_reg, fmt_next;
    logic [11:0]    x_reg, x_next;
    logic [11:0]    y_reg, y_next;
    logic [11:0]    z_reg, z_next;
    logic [31:0]    wr_reg [4];
    logic [31:0]    wr_next [4];
    zh_t            zh_reg, zh_next;
    lin_t           lin_reg, lin_next;
    off_t           off_reg, off_next;
    logic           cfault_reg, cfault_next;
    logic           fault_reg, fault_next;
    logic [1:0]     rd_ch_reg, rd_ch_next;
    logic [31:0]    acc_reg [4];
    logic [31:0]    acc_next [4];
    logic [127:0]   m_data_reg, m_data_next;
    logic           m_fault_reg, m_fault_next;

    // datapath
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;
    logic [4:0]     tex_size;
    fmt_t           st_code;
    fmt_t           acc_code;
    logic           issue;
    logic [4:0]     k_sh;
    logic [1:0]     cur_ch;
    logic [1:0]     bmask;
    logic [1:0]     byte_sel;
    logic [31:0]    wval;
    logic [7:0]     wbyte;
    logic           fault_chk;
    logic           out_free;
    logic           cfg_wr;
    logic [31:0]    res [4];

    // texel byte store
    tsfc_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // texel layout
    assign tex_size = 5'(cfg_count_reg) * 5'(cfg_bytes_reg);
    assign st_code  = bytes_fmt(cfg_bytes_reg);
    assign acc_code = fmt_norm(fmt_reg);

    // byte walk: channel and big-endian byte position of byte k
    assign issue    = (k_reg != tex_size);
    assign k_sh     = k_reg >> st_code;
    assign cur_ch   = k_sh[1:0];
    assign bmask    = 2'(cfg_bytes_reg - 3'd1);
    assign byte_sel = bmask - (k_reg[1:0] & bmask);
    assign wval     = fmt_convert(wr_reg[cur_ch], acc_code, st_code);
    assign wbyte    = wval[{byte_sel, 3'b000} +: 8];

    // range check of the texel's last byte
    assign fault_chk = cfault_reg ||
                       ((off_sum_t'(off_reg) + off_sum_t'(tex_size)) > MEM_LIM);

    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite;

    // result channels in the access format
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (fault_reg || action_reg) begin
                res[c] = 32'd0;
            end else if (3'(c) < cfg_count_reg) begin
                res[c] = fmt_convert(acc_reg[c], st_code, acc_code);
            end else if (c == 3) begin
                res[c] = fmt_mask(acc_code);
            end else begin
                res[c] = 32'd0;
            end
        end
    end

    // controller and register writes
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        k_next          = k_reg;
        rd_pend_next    = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        cfg_depth_next  = cfg_depth_reg;
        cfg_count_next  = cfg_count_reg;
        cfg_bytes_next  = cfg_bytes_reg;
        action_next     = action_reg;
        fmt_next        = fmt_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        zh_next         = zh_reg;
        lin_next        = lin_reg;
        off_next        = off_reg;
        cfault_next     = cfault_reg;
        fault_next      = fault_reg;
        rd_ch_next      = rd_ch_reg;
        m_data_next     = m_data_reg;
        m_fault_next    = m_fault_reg;
        for (int c = 0; c < 4; c++) begin
            wr_next[c]  = wr_reg[c];
            acc_next[c] = acc_reg[c];
        end
        ram_we    = 1'b0;
        ram_addr  = off_reg[AW-1:0] + AW'(k_reg);
        ram_wdata = wbyte;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = 8'd0;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tuser[0];
                    fmt_next    = s_tuser[2:1];
                    x_next      = s_tdata[11:0];
                    y_next      = s_tdata[23:12];
                    z_next      = s_tdata[35:24];
                    wr_next[0]  = s_tdata[67:36];
                    wr_next[1]  = s_tdata[99:68];
                    wr_next[2]  = s_tdata[131:100];
                    wr_next[3]  = s_tdata[163:132];
                    state_next  = ST_ROW;
                end
            end
            ST_ROW: begin
                cfault_next = ({1'b0, x_reg} >= cfg_width_reg) ||
                              ({1'b0, y_reg} >= cfg_height_reg) ||
                              ({1'b0, z_reg} >= cfg_depth_reg);
                zh_next     = zh_t'(z_reg) * zh_t'(cfg_height_reg) + zh_t'(y_reg);
                state_next  = ST_LIN;
            end
            ST_LIN: begin
                lin_next   = lin_t'(zh_reg) * lin_t'(cfg_width_reg) + lin_t'(x_reg);
                state_next = ST_OFF;
            end
            ST_OFF: begin
                off_next   = off_t'(lin_reg) * off_t'(tex_size);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                fault_next = fault_chk;
                k_next     = 5'd0;
                for (int c = 0; c < 4; c++) begin
                    acc_next[c] = 32'd0;
                end
                if (fault_chk || (tex_size == 5'd0)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER: begin
                if (issue) begin
                    ram_we       = action_reg;
                    rd_pend_next = !action_reg;
                    rd_ch_next   = cur_ch;
                    k_next       = k_reg + 5'd1;
                end else if (!rd_pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next   = {res[3], res[2], res[1], res[0]};
                    m_fault_next  = fault_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // read byte lands in the cycle after its address, shift in big-endian
        if (rd_pend_reg) begin
            acc_next[rd_ch_reg] = {acc_reg[rd_ch_reg][23:0], ram_rdata};
        end

        // register writes with clamping
        if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_GRID_WIDTH:    cfg_width_next  = pwdata[12:0];
                REG_GRID_HEIGHT:   cfg_height_next = pwdata[12:0];
                REG_GRID_DEPTH:    cfg_depth_next  = pwdata[12:0];
                REG_CHANNEL_COUNT: cfg_count_next  = (pwdata[2:0] > 3'd4) ? 3'd4 : pwdata[2:0];
                REG_CHANNEL_BYTES: begin
                    if (pwdata[2:0] == 3'd0) begin
                        cfg_bytes_next = 3'd1;
                    end else if (pwdata[2:0] > 3'd2) begin
                        cfg_bytes_next = 3'd4;
                    end else begin
                        cfg_bytes_next = pwdata[2:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            REG_GRID_WIDTH:    prdata = {19'd0, cfg_width_reg};
            REG_GRID_HEIGHT:   prdata = {19'd0, cfg_height_reg};
            REG_GRID_DEPTH:    prdata = {19'd0, cfg_depth_reg};
            REG_CHANNEL_COUNT: prdata = {29'd0, cfg_count_reg};
            REG_CHANNEL_BYTES: prdata = {29'd0, cfg_bytes_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            k_reg          <= 5'd0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cfg_width_reg  <= 13'd0;
            cfg_height_reg <= 13'd0;
            cfg_depth_reg  <= 13'd0;
            cfg_count_reg  <= 3'd3;
            cfg_bytes_reg  <= 3'd1;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            k_reg          <= k_next;
            rd_pend_reg    <= rd_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            cfg_depth_reg  <= cfg_depth_next;
            cfg_count_reg  <= cfg_count_next;
            cfg_bytes_reg  <= cfg_bytes_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        fmt_reg     <= fmt_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zh_reg      <= zh_next;
        lin_reg     <= lin_next;
        off_reg     <= off_next;
        cfault_reg  <= cfault_next;
        fault_reg   <= fault_next;
        rd_ch_reg   <= rd_ch_next;
        m_data_reg  <= m_data_next;
        m_fault_reg <= m_fault_next;
        for (int c = 0; c < 4; c++) begin
            wr_reg[c]  <= wr_next[c];
            acc_reg[c] <= acc_next[c];
        end
    end

    // ports
    assign pready     = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_fault_reg;

    // checks
    `TSFC_ASSERT_SAME(a_store_write_legal, aclk, aresetn, ram_we && (state_reg != ST_CLEAR), (state_reg == ST_XFER) && action_reg && !fault_reg, "texel store written outside a valid write transaction")
    `TSFC_ASSERT_SAME(a_fault_zero_data, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 128'd0, "faulted result carries nonzero channels")
    `TSFC_ASSERT_SAME(a_result_from_done, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_DONE), "result raised without a finished access")

endmodule

// File: hdl/tsfc_ram.sv
`timescale 1ns / 1ps

module tsfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
